// ===== rtl/core/cbip_pkg.sv =====
// ----------------------------------------------------------------------------
// cbip_pkg: shared types and constants of the custom base integer parser
// Character codes, configuration register indexes, the queue entry that the
// front part hands to the back part, and the parse phase encoding.
// ----------------------------------------------------------------------------
package cbip_pkg;

   // digit symbol set
   localparam int MAX_SYMBOLS = 16;
   localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
   localparam int COUNT_W     = 5;
   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;

   // queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYMBOLS_LOW  = 2'd0,
      CSR_SYMBOLS_HIGH = 2'd1,
      CSR_SYMBOL_COUNT = 2'd2
   } csr_index_type;

   // parse phase, one-hot
   typedef enum logic [3:0] {
      PH_SPACE = 4'b0001,
      PH_SIGN  = 4'b0010,
      PH_DIGIT = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   // classified byte as queued for the back part
   typedef struct packed {
      logic                 is_nul;
      logic                 is_space;
      logic                 is_plus;
      logic                 is_minus;
      logic                 is_digit;
      logic [SYM_IDX_W-1:0] digit;
      logic                 base_valid;
      logic [COUNT_W-1:0]   count;
   } entry_type;

endpackage

// ===== rtl/core/cbip_front.sv =====
// ----------------------------------------------------------------------------
// cbip_front: configuration registers and byte classifier
// Holds the symbol set, checks it for a valid base and sorts each input beat
// into NUL, whitespace, sign or digit with its symbol index.
// ----------------------------------------------------------------------------
module cbip_front import cbip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CHAR_W-1:0]     char_in,
   output entry_type             entry
);

   logic [CSR_DATA_W-1:0] sym_low_ff, sym_low_in;
   logic [CSR_DATA_W-1:0] sym_high_ff, sym_high_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [2*CSR_DATA_W-1:0] sym_all;
   logic [CHAR_W-1:0]      sym [MAX_SYMBOLS];
   logic [MAX_SYMBOLS-1:0] in_use;
   logic                   any_bad;
   logic                   any_dup;
   logic                   base_valid;
   logic                   hit;
   logic [SYM_IDX_W-1:0]   hit_idx;

   // register writes
   always_comb begin
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      count_in    = count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYMBOLS_LOW:  sym_low_in  = csr_write_data;
            CSR_SYMBOLS_HIGH: sym_high_in = csr_write_data;
            CSR_SYMBOL_COUNT: count_in    = csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         count_ff    <= '0;
      end else begin
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
         count_ff    <= count_in;
      end
   end

   // unpack symbols and mark those in use
   assign sym_all = {sym_high_ff, sym_low_ff};

   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         sym[k]    = sym_all[k*CHAR_W +: CHAR_W];
         in_use[k] = (COUNT_W'(k) < count_ff);
      end
   end

   // base check: forbidden symbols and duplicates
   always_comb begin
      any_bad = 1'b0;
      any_dup = 1'b0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (in_use[i] && (sym[i] <= CHAR_SPACE || sym[i] >= CHAR_DEL ||
                           sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS))
            any_bad = 1'b1;
         for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
            if (in_use[i] && in_use[j] && sym[i] == sym[j])
               any_dup = 1'b1;
         end
      end
   end

   assign base_valid = (count_ff >= COUNT_W'(2)) && (count_ff <= COUNT_W'(MAX_SYMBOLS)) &&
                       !any_bad && !any_dup;

   // first matching symbol wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (in_use[i] && sym[i] == char_in) begin
            hit     = 1'b1;
            hit_idx = SYM_IDX_W'(i);
         end
      end
   end

   // classified beat
   always_comb begin
      entry.is_nul     = (char_in == CHAR_NUL);
      entry.is_space   = (char_in >= CHAR_TAB && char_in <= CHAR_CR) ||
                         (char_in == CHAR_SPACE);
      entry.is_plus    = (char_in == CHAR_PLUS);
      entry.is_minus   = (char_in == CHAR_MINUS);
      entry.is_digit   = hit && base_valid;
      entry.digit      = hit_idx;
      entry.base_valid = base_valid;
      entry.count      = count_ff;
   end

endmodule

// ===== rtl/core/cbip_queue.sv =====
// ----------------------------------------------------------------------------
// cbip_queue: short queue of classified beats
// Lets the classifier keep taking beats while the back part is stalled.
// ----------------------------------------------------------------------------
module cbip_queue import cbip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   entry_type              mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (fill_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_entry = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop)
         fill_in = fill_ff + 1'b1;
      else if (pop && !push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= in_entry;
   end

endmodule

// ===== rtl/core/cbip_back.sv =====
// ----------------------------------------------------------------------------
// cbip_back: parse sequencer and result register
// Walks whitespace, sign and digit phases, accumulates digits and holds the
// result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cbip_back import cbip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  entry_type                 in_entry,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_base_valid
);

   phase_type            phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic                 out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]   out_value_ff, out_value_in;
   logic                 out_bv_ff, out_bv_in;
   logic                 take;
   logic                 emit;
   logic [VALUE_W-1:0]   product;

   // a beat moves on when the result register is free or draining
   assign in_ready = !out_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign product  = acc_ff * VALUE_W'(in_entry.count);

   // phase step
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      emit     = 1'b0;
      if (take) begin
         if (phase_ff == PH_DONE) begin
            if (in_entry.is_nul) begin
               phase_in = PH_SPACE;
               neg_in   = 1'b0;
               acc_in   = '0;
            end
         end else if (!in_entry.is_nul && phase_ff == PH_SPACE && in_entry.is_space) begin
            phase_in = phase_ff;
         end else if (!in_entry.is_nul && phase_ff != PH_DIGIT &&
                      (in_entry.is_plus || in_entry.is_minus)) begin
            neg_in   = neg_ff ^ in_entry.is_minus;
            phase_in = PH_SIGN;
         end else if (!in_entry.is_nul && in_entry.is_digit) begin
            acc_in   = product + VALUE_W'(in_entry.digit);
            phase_in = PH_DIGIT;
         end else begin
            emit     = 1'b1;
            phase_in = in_entry.is_nul ? PH_SPACE : PH_DONE;
            neg_in   = 1'b0;
            acc_in   = '0;
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_bv_in    = out_bv_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_bv_in    = in_entry.base_valid;
         if (!in_entry.base_valid)
            out_value_in = '0;
         else if (neg_ff)
            out_value_in = '0 - acc_ff;
         else
            out_value_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_bv_ff    <= out_bv_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_base_valid = out_bv_ff;

endmodule

// ===== rtl/core/custom_base_integer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// custom_base_integer_parser_unit: string to integer in a configurable base
// Each req beat carries one byte of a NUL-terminated string. The csr port
// loads up to sixteen digit symbols and their count, which is the base; the
// user must write it only while no string is in flight, which the block does
// not enforce. Leading whitespace is skipped, a run of signs follows, then
// digits accumulate with 32-bit wrap. The first byte that is not a digit
// gives one rsp beat with the value and a base-valid flag; an invalid base
// gives 0. Bytes after it are dropped until NUL, which also gives a beat if
// no result was sent for that string. Throughput is one byte per cycle
// while the receiver does not stall: the classifier takes a beat each cycle,
// and the back part consumes one queued beat per cycle with a single
// multiply-add. The terminating byte passes through the queue and then the
// result register on its way to rsp_valid. When the receiver stalls, the
// result register holds its beat and the back part stops; the two-entry
// queue then fills and req_ready falls. Synchronous reset clears the symbol
// set, the parse state and both channels; no beats are held afterwards.
// ----------------------------------------------------------------------------
module custom_base_integer_parser_unit import cbip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CHAR_W-1:0]         req_char_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_base_valid,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   entry_type front_entry;
   entry_type q_entry;
   logic      q_valid;
   logic      q_ready;

   // classifier and configuration
   cbip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .char_in          (req_char_in),
      .entry            (front_entry)
   );

   // decoupling queue
   cbip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_entry  (front_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   // parse sequencer
   cbip_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_ready       (q_ready),
      .in_entry       (q_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_base_valid (rsp_base_valid)
   );

   // an invalid base always reports zero
   a_invalid_base_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_base_valid |-> rsp_value == '0)
      else $error("invalid base beat with nonzero value");

   // a full queue must be presenting a beat to the back part
   a_full_queue_valid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("queue full but empty towards back part");

   // no result beat straight after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present after reset");

endmodule

// ===== tb/sv/parse_result_check.sv =====
// ----------------------------------------------------------------------------
// parse_result_check: predicts and checks the results of the base parser
// Watches the csr, req and rsp ports of the custom base integer parser. It
// keeps its own copy of the symbol registers and of the parse state, works
// out the result of each accepted byte, and compares every rsp beat field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module parse_result_check import cbip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [CHAR_W-1:0]         req_char_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_value,
   input  logic                      rsp_base_valid,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   output int                        outstanding,
   output int                        mismatches
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      base_valid;
   } parse_result_type;

   // shadow of the symbol registers
   logic [2*CSR_DATA_W-1:0] symbols;
   logic [COUNT_W-1:0]      symbol_count;

   // parse state of the string in flight
   phase_type               phase;
   logic                    negative;
   logic [VALUE_W-1:0]      accumulator;

   parse_result_type        expected_results[$];
   int                      fail_total;

   // a base needs two or more distinct printable symbols, none of them a sign
   function automatic logic base_is_valid();
      logic [CHAR_W-1:0] sym;
      if (symbol_count < 2 || symbol_count > MAX_SYMBOLS)
         return 1'b0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (i < symbol_count) begin
            sym = symbols[CHAR_W*i +: CHAR_W];
            if (sym <= CHAR_SPACE || sym >= CHAR_DEL || sym == CHAR_PLUS || sym == CHAR_MINUS)
               return 1'b0;
            for (int j = i + 1; j < MAX_SYMBOLS; j++)
               if (j < symbol_count && symbols[CHAR_W*j +: CHAR_W] == sym)
                  return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // position of the first matching symbol, -1 when the byte is no digit
   function automatic int digit_index(input logic [CHAR_W-1:0] c, input logic valid_base);
      if (!valid_base)
         return -1;
      for (int i = 0; i < MAX_SYMBOLS; i++)
         if (i < symbol_count && symbols[CHAR_W*i +: CHAR_W] == c)
            return i;
      return -1;
   endfunction

   function automatic void clear_string();
      phase       = PH_SPACE;
      negative    = 1'b0;
      accumulator = '0;
   endfunction

   // advance the parse by one byte, queueing a result where one is due
   function automatic void parse_byte(input logic [CHAR_W-1:0] c);
      logic               valid_base;
      int                 d;
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] digit_value;
      parse_result_type   result;
      valid_base = base_is_valid();
      if (phase == PH_DONE) begin
         if (c == CHAR_NUL)
            clear_string();
         return;
      end
      if (c != CHAR_NUL) begin
         if (phase == PH_SPACE && ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE))
            return;
         if (phase != PH_DIGIT && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            if (c == CHAR_MINUS)
               negative = ~negative;
            phase = PH_SIGN;
            return;
         end
         d = digit_index(c, valid_base);
         if (d >= 0) begin
            base        = VALUE_W'(symbol_count);
            digit_value = VALUE_W'(d);
            accumulator = accumulator * base + digit_value;
            phase       = PH_DIGIT;
            return;
         end
      end
      // this byte ends the number
      if (!valid_base)
         result.value = '0;
      else if (negative)
         result.value = '0 - accumulator;
      else
         result.value = accumulator;
      result.base_valid = valid_base;
      expected_results.push_back(result);
      if (c == CHAR_NUL)
         clear_string();
      else begin
         phase       = PH_DONE;
         negative    = 1'b0;
         accumulator = '0;
      end
   endfunction

   always @(posedge clock) begin : watch
      parse_result_type want;
      if (reset) begin
         symbols      = '0;
         symbol_count = '0;
         clear_string();
         expected_results.delete();
         fail_total   = 0;
      end else begin
         // result beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (fail_total < REPORT_LIMIT)
                  $display("unexpected result beat: value %0d base_valid %0b",
                           rsp_value, rsp_base_valid);
               fail_total++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value || rsp_base_valid !== want.base_valid) begin
                  if (fail_total < REPORT_LIMIT)
                     $display("mismatch: value exp %0d got %0d, base_valid exp %0b got %0b",
                              want.value, rsp_value, want.base_valid, rsp_base_valid);
                  fail_total++;
               end
            end
         end
         // byte beat into the predictor
         if (req_valid && req_ready)
            parse_byte(req_char_in);
         // register writes take effect from the next byte
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SYMBOLS_LOW:  symbols[CSR_DATA_W-1:0] = csr_write_data;
               CSR_SYMBOLS_HIGH: symbols[2*CSR_DATA_W-1:CSR_DATA_W] = csr_write_data;
               CSR_SYMBOL_COUNT: symbol_count = csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_results.size();
      mismatches  <= fail_total;
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the custom base integer parser
// Loads a series of digit symbol sets, valid and invalid, and feeds strings
// of whitespace, signs, digits and noise with random gaps on both channels,
// including one long receiver stall. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import cbip_pkg::*;

   localparam int ITEM_TARGET   = 1700;
   localparam int MAX_GAP       = 5;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 60;
   localparam int STALL_PHASE   = 3;
   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = CHAR_W'(CHAR_SPACE + 1);
   localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = CHAR_W'(CHAR_DEL - 1);
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = "0";
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = "A";
   localparam logic [CHAR_W-1:0] CHAR_TOP_HALF   = 8'h80;

   typedef enum int {
      SET_DECIMAL,
      SET_BINARY,
      SET_HEX,
      SET_RANDOM,
      SET_DUPLICATE,
      SET_BAD_SYMBOL,
      SET_SHORT,
      SET_KIND_COUNT
   } symbol_set_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [CHAR_W-1:0]         req_char_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      rsp_base_valid;
   logic                      csr_write_enable;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_write_data;
   int                        outstanding;
   int                        mismatches;

   logic                      quiet;
   logic                      hold_off;
   logic                      stall_go;
   logic [2*CSR_DATA_W-1:0]   cur_symbols;
   int                        cur_count;
   int                        sent;

   custom_base_integer_parser_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_base_valid   (rsp_base_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   parse_result_check result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_base_valid   (rsp_base_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .mismatches       (mismatches)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop for a hung run
   initial begin : watchdog
      #4000000;
      $display("FAIL custom_base_integer_parser_unit");
      $finish;
   end

   // distinct printable symbols, sometimes at the ends of the printable range
   function automatic logic [2*CSR_DATA_W-1:0] random_symbols(input int n);
      logic [2*CSR_DATA_W-1:0] s;
      logic [255:0]            taken;
      logic [CHAR_W-1:0]       b;
      s     = {$urandom, $urandom, $urandom, $urandom};
      taken = '0;
      for (int i = 0; i < n; i++) begin
         if (i == 0 && $urandom_range(0, 3) == 0)
            b = FIRST_PRINTABLE;
         else if (i == n - 1 && !taken[LAST_PRINTABLE] && $urandom_range(0, 3) == 0)
            b = LAST_PRINTABLE;
         else begin
            b = CHAR_W'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
            while (taken[b] || b == CHAR_PLUS || b == CHAR_MINUS)
               b = CHAR_W'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
         end
         taken[b] = 1'b1;
         s[CHAR_W*i +: CHAR_W] = b;
      end
      return s;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_space();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CHAR_SPACE : CHAR_W'(CHAR_TAB + r);
   endfunction

   // a symbol of the current set; any of the sixteen slots when none is in use
   function automatic logic [CHAR_W-1:0] some_digit();
      int k;
      k = $urandom_range(0, (cur_count > 0) ? cur_count - 1 : MAX_SYMBOLS - 1);
      return cur_symbols[CHAR_W*k +: CHAR_W];
   endfunction

   // one req beat after a random gap; valid stays up across back-to-back beats
   task automatic send_byte(input logic [CHAR_W-1:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // drop valid, wait for every result and let the queue drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_symbol_set(input symbol_set_type kind);
      int                    n;
      int                    i;
      int                    j;
      logic [CHAR_W-1:0]     bad;
      logic [CSR_DATA_W-1:0] count_word;
      n = $urandom_range(2, MAX_SYMBOLS);
      case (kind)
         SET_DECIMAL: begin
            n = 10;
            cur_symbols = {$urandom, $urandom, $urandom, $urandom};
            for (i = 0; i < 10; i++)
               cur_symbols[CHAR_W*i +: CHAR_W] = CHAR_W'(CHAR_ZERO + i);
         end
         SET_BINARY: begin
            n = 2;
            cur_symbols = random_symbols(n);
         end
         SET_HEX: begin
            n = MAX_SYMBOLS;
            for (i = 0; i < MAX_SYMBOLS; i++)
               cur_symbols[CHAR_W*i +: CHAR_W] = (i < 10) ? CHAR_W'(CHAR_ZERO + i) :
                                                             CHAR_W'(CHAR_UPPER_A + i - 10);
         end
         SET_RANDOM:
            cur_symbols = random_symbols(n);
         SET_DUPLICATE: begin
            cur_symbols = random_symbols(n);
            i = $urandom_range(0, n - 1);
            j = $urandom_range(0, n - 2);
            if (j >= i)
               j++;
            cur_symbols[CHAR_W*j +: CHAR_W] = cur_symbols[CHAR_W*i +: CHAR_W];
         end
         SET_BAD_SYMBOL: begin
            cur_symbols = random_symbols(n);
            case ($urandom_range(0, 4))
               0:       bad = CHAR_W'($urandom_range(0, CHAR_SPACE));
               1:       bad = CHAR_DEL;
               2:       bad = CHAR_W'($urandom_range(CHAR_TOP_HALF, 255));
               3:       bad = CHAR_PLUS;
               default: bad = CHAR_MINUS;
            endcase
            i = $urandom_range(0, n - 1);
            cur_symbols[CHAR_W*i +: CHAR_W] = bad;
         end
         default: begin
            // too few symbols, with all-zero or all-one registers
            n = $urandom_range(0, 1);
            if ($urandom_range(0, 1))
               cur_symbols = {2*CSR_DATA_W{1'b1}};
            else
               cur_symbols = '0;
         end
      endcase
      cur_count  = n;
      count_word = CSR_DATA_W'(n);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYMBOLS_LOW;
      csr_write_data   <= cur_symbols[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index        <= CSR_SYMBOLS_HIGH;
      csr_write_data   <= cur_symbols[2*CSR_DATA_W-1:CSR_DATA_W];
      @(posedge clock);
      csr_index        <= CSR_SYMBOL_COUNT;
      csr_write_data   <= count_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // whitespace, signs, digits, then NUL or an ending byte and trailing junk
   task automatic send_number();
      int                n;
      logic [CHAR_W-1:0] b;
      repeat ($urandom_range(0, 3)) send_byte(pick_space());
      n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      repeat (n) send_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 34) : $urandom_range(0, 10);
      repeat (n) send_byte(some_digit());
      if ($urandom_range(0, 1)) begin
         b = CHAR_W'($urandom_range(1, 255));
         send_byte(b);
         repeat ($urandom_range(0, 3)) begin
            b = CHAR_W'($urandom_range(1, 255));
            send_byte(b);
         end
      end
      send_byte(CHAR_NUL);
   endtask

   // short run of arbitrary bytes, closed by NUL
   task automatic send_noise();
      logic [CHAR_W-1:0] b;
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 3))
            0:       b = CHAR_W'($urandom_range(0, 255));
            1:       b = some_digit();
            2:       b = pick_space();
            default: b = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
         endcase
         send_byte(b);
      end
      send_byte(CHAR_NUL);
   endtask

   // result side: random gap after each beat, off during the long hold
   initial begin : result_sink
      int wait_left;
      wait_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            wait_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
         else if (!rsp_ready && wait_left > 0)
            wait_left--;
         rsp_ready <= !reset && !hold_off && wait_left == 0;
      end
   end

   // one long receiver stall so the queue fills and req_ready falls
   initial begin : long_hold
      hold_off <= 1'b0;
      wait (stall_go === 1'b1);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      symbol_set_type kind;
      int             phase_no;
      int             r;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_char_in      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SYMBOLS_LOW;
      csr_write_data   <= '0;
      quiet            <= 1'b0;
      stall_go         <= 1'b0;
      cur_symbols = '0;
      cur_count   = 0;
      sent        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty symbol set after reset: no digit matches, result comes at once
      send_byte(CHAR_MINUS);
      send_byte("7");
      send_byte(CHAR_NUL);
      settle();

      // full sixteen-symbol set: whitespace, sign run, wrap, junk after the end
      load_symbol_set(SET_HEX);
      send_byte(CHAR_TAB);
      send_byte(CHAR_CR);
      send_byte(CHAR_SPACE);
      send_byte(CHAR_MINUS);
      send_byte(CHAR_PLUS);
      send_byte(CHAR_MINUS);
      repeat (9) send_byte("F");
      send_byte("g");
      send_byte(8'hFF);
      send_byte(CHAR_NUL);
      // empty string, then whitespace right after a sign
      send_byte(CHAR_NUL);
      send_byte(CHAR_MINUS);
      send_byte(CHAR_SPACE);
      send_byte("5");
      send_byte(CHAR_NUL);

      // random phases, each with its own symbol set
      phase_no = 0;
      while (sent < ITEM_TARGET) begin
         settle();
         if (phase_no < SET_KIND_COUNT)
            kind = symbol_set_type'(phase_no);
         else begin
            r = $urandom_range(0, 9);
            kind = (r < SET_KIND_COUNT) ? symbol_set_type'(r) : SET_RANDOM;
         end
         load_symbol_set(kind);
         quiet    <= (phase_no == STALL_PHASE) || ($urandom_range(0, 3) == 0);
         stall_go <= (phase_no == STALL_PHASE);
         repeat ($urandom_range(6, 16)) begin
            if ($urandom_range(0, 4) == 0)
               send_noise();
            else
               send_number();
         end
         phase_no++;
      end
      settle();

      if (mismatches == 0 && outstanding == 0)
         $display("PASS custom_base_integer_parser_unit");
      else
         $display("FAIL custom_base_integer_parser_unit");
      $finish;
   end

endmodule
